>>> rtl/bsf_pkg.sv
// Package for the byte stuffing framer: constants, register indexes and the command type.
package bsf_pkg;

  localparam int unsigned SeqBits = 8;
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW = $clog2(QDepth);
  localparam int unsigned QCntW = $clog2(QDepth + 1);
  localparam int unsigned CfgIdxW = 2;

  localparam logic [7:0] FlagReset = 8'd36;
  localparam logic [7:0] EscReset = 8'd47;

  localparam logic [CfgIdxW-1:0] RegFlag = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] RegEsc = CfgIdxW'(1);

  // One classified item, with the register values current at its acceptance.
  typedef struct packed {
    logic       do_open;
    logic       do_esc;
    logic       do_byte;
    logic       do_close;
    logic [7:0] flag;
    logic [7:0] esc;
    logic [7:0] data;
    logic [7:0] parity;
    logic [7:0] seq;
  } bsf_cmd_t;

endpackage

>>> rtl/bsf_front.sv
// Front end of the framer: configuration registers, frame state and item classification.
module bsf_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [bsf_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [7:0]                    cfg_data_i,
  input  logic                          accept_i,
  input  logic [7:0]                    payload_byte_i,
  input  logic                          has_byte_i,
  input  logic                          end_of_message_i,
  output logic                          cmd_valid_o,
  output bsf_pkg::bsf_cmd_t             cmd_o
);

  logic [7:0]                 flag_q, flag_d;
  logic [7:0]                 esc_q, esc_d;
  logic                       open_q, open_d;
  logic [7:0]                 parity_q, parity_d;
  logic [bsf_pkg::SeqBits-1:0] cnt_q, cnt_d;
  logic [7:0]                 new_parity;
  logic                       busy_item;

  assign cfg_ready_o = 1'b1;
  assign busy_item = has_byte_i | end_of_message_i;
  assign new_parity = has_byte_i ? (parity_q ^ payload_byte_i) : parity_q;

  always_comb begin
    flag_d = flag_q;
    esc_d = esc_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        bsf_pkg::RegFlag: flag_d = cfg_data_i;
        bsf_pkg::RegEsc:  esc_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    open_d = open_q;
    parity_d = parity_q;
    cnt_d = cnt_q;
    if (accept_i && busy_item) begin
      if (end_of_message_i) begin
        open_d = 1'b0;
        parity_d = 8'd0;
        cnt_d = cnt_q + bsf_pkg::SeqBits'(1);
      end else begin
        open_d = 1'b1;
        parity_d = new_parity;
      end
    end
  end

  always_comb begin
    cmd_valid_o = accept_i & busy_item;
    cmd_o.do_open = ~open_q;
    cmd_o.do_esc = has_byte_i & ((payload_byte_i == flag_q) | (payload_byte_i == esc_q));
    cmd_o.do_byte = has_byte_i;
    cmd_o.do_close = end_of_message_i;
    cmd_o.flag = flag_q;
    cmd_o.esc = esc_q;
    cmd_o.data = payload_byte_i;
    cmd_o.parity = new_parity;
    cmd_o.seq = 8'(cnt_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flag_q <= bsf_pkg::FlagReset;
      esc_q <= bsf_pkg::EscReset;
      open_q <= 1'b0;
      parity_q <= 8'd0;
      cnt_q <= '0;
    end else begin
      flag_q <= flag_d;
      esc_q <= esc_d;
      open_q <= open_d;
      parity_q <= parity_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

>>> rtl/bsf_queue.sv
// Short command queue between the front end and the byte emitter.
module bsf_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  bsf_pkg::bsf_cmd_t data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              empty_o,
  output bsf_pkg::bsf_cmd_t data_o
);

  bsf_pkg::bsf_cmd_t             mem_q [bsf_pkg::QDepth];
  logic [bsf_pkg::QPtrW-1:0]     wr_q, wr_d, rd_q, rd_d;
  logic [bsf_pkg::QCntW-1:0]     cnt_q, cnt_d;
  logic                          do_push, do_pop;

  assign full_o = (cnt_q == bsf_pkg::QCntW'(bsf_pkg::QDepth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i & ~full_o;
  assign do_pop = pop_i & ~empty_o;
  assign data_o = mem_q[rd_q];

  always_comb begin
    wr_d = do_push ? wr_q + bsf_pkg::QPtrW'(1) : wr_q;
    rd_d = do_pop ? rd_q + bsf_pkg::QPtrW'(1) : rd_q;
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + bsf_pkg::QCntW'(1);
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - bsf_pkg::QCntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
      cnt_q <= '0;
    end else begin
      wr_q <= wr_d;
      rd_q <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

>>> rtl/bsf_back.sv
// Back end of the framer: walks each command and emits its bytes into an output register.
module bsf_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_empty_i,
  input  bsf_pkg::bsf_cmd_t cmd_i,
  output logic              q_pop_o,
  output logic              empty_o,
  input  logic              pop_i,
  output logic [7:0]        out_byte_o,
  output logic              last_of_run_o,
  output logic              frame_done_o,
  output logic [7:0]        parity_out_o,
  output logic [7:0]        sequence_out_o
);

  logic [3:0] rem_q, rem_d, mask, sel;
  logic       rem_vld_q, rem_vld_d;
  logic       out_vld_q, out_vld_d;
  logic       advance;
  logic [7:0] byte_d, par_d, seq_d;
  logic       last_d, done_d;
  logic [7:0] out_byte_q, par_q, seq_q;
  logic       last_q, done_q;

  // Mask bits from low to high: opening flag, escape, payload byte, closing flag.
  assign mask = rem_vld_q ? rem_q : {cmd_i.do_close, cmd_i.do_byte, cmd_i.do_esc, cmd_i.do_open};
  assign advance = ~q_empty_i & (~out_vld_q | pop_i);
  assign empty_o = ~out_vld_q;
  assign out_byte_o = out_byte_q;
  assign last_of_run_o = last_q;
  assign frame_done_o = done_q;
  assign parity_out_o = par_q;
  assign sequence_out_o = seq_q;

  always_comb begin
    sel = 4'b0000;
    byte_d = cmd_i.flag;
    done_d = 1'b0;
    par_d = 8'd0;
    seq_d = 8'd0;
    priority if (mask[0]) begin
      sel = 4'b0001;
    end else if (mask[1]) begin
      sel = 4'b0010;
      byte_d = cmd_i.esc;
    end else if (mask[2]) begin
      sel = 4'b0100;
      byte_d = cmd_i.data;
    end else begin
      sel = 4'b1000;
      done_d = 1'b1;
      par_d = cmd_i.parity;
      seq_d = cmd_i.seq;
    end
    last_d = ((mask & ~sel) == 4'b0000);
  end

  always_comb begin
    rem_d = rem_q;
    rem_vld_d = rem_vld_q;
    q_pop_o = 1'b0;
    out_vld_d = out_vld_q & ~pop_i;
    if (advance) begin
      out_vld_d = 1'b1;
      rem_d = mask & ~sel;
      rem_vld_d = ~last_d;
      q_pop_o = last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_byte_q <= byte_d;
      last_q <= last_d;
      done_q <= done_d;
      par_q <= par_d;
      seq_q <= seq_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= 4'b0000;
      rem_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      rem_q <= rem_d;
      rem_vld_q <= rem_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

endmodule

>>> rtl/byte_stuffing_framer_with_parity.sv
// Top level of the byte stuffing framer with XOR parity and frame sequence number.
//
//   Channel   Handshake                  Beat contents
//   input     push / full                payload_byte_i, has_byte_i, end_of_message_i
//   result    pop / empty                out_byte_o, last_of_run_o, frame_done_o,
//                                        parity_out_o, sequence_out_o
//   config    cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// The front end takes one input beat per cycle while the command queue has room.
// The back end emits one result beat per cycle while the result side is not stalled, one beat
// per byte an item produces (one to four); the emitter is the limit on sustained rate.
// An item's first result passes the command queue and then the output register.
// Reset sets the registers to their defaults and closes any open frame.
// A stalled result side fills the four-entry queue and then raises full.
module byte_stuffing_framer_with_parity (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push,
  output logic                        full,
  input  logic [7:0]                  payload_byte_i,
  input  logic                        has_byte_i,
  input  logic                        end_of_message_i,
  output logic                        empty,
  input  logic                        pop,
  output logic [7:0]                  out_byte_o,
  output logic                        last_of_run_o,
  output logic                        frame_done_o,
  output logic [7:0]                  parity_out_o,
  output logic [7:0]                  sequence_out_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [bsf_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [7:0]                  cfg_data_i
);

  bsf_pkg::bsf_cmd_t cmd, head;
  logic              cmd_valid, q_empty, q_pop, accept;

  assign accept = push & ~full;

  bsf_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .accept_i         (accept),
    .payload_byte_i   (payload_byte_i),
    .has_byte_i       (has_byte_i),
    .end_of_message_i (end_of_message_i),
    .cmd_valid_o      (cmd_valid),
    .cmd_o            (cmd)
  );

  bsf_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_valid),
    .data_i  (cmd),
    .full_o  (full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .data_o  (head)
  );

  bsf_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_empty_i      (q_empty),
    .cmd_i          (head),
    .q_pop_o        (q_pop),
    .empty_o        (empty),
    .pop_i          (pop),
    .out_byte_o     (out_byte_o),
    .last_of_run_o  (last_of_run_o),
    .frame_done_o   (frame_done_o),
    .parity_out_o   (parity_out_o),
    .sequence_out_o (sequence_out_o)
  );

endmodule

>>> verif/tb_byte_stuffing_framer_with_parity.sv
// Self-checking testbench for the byte stuffing framer with XOR parity and sequence number.
module tb_byte_stuffing_framer_with_parity;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [bsf_pkg::CfgIdxW-1:0] RegSpareA = bsf_pkg::CfgIdxW'(2);
  localparam logic [bsf_pkg::CfgIdxW-1:0] RegSpareB = bsf_pkg::CfgIdxW'(3);
  localparam int unsigned StallLimit = 4000;
  localparam int unsigned DrainCycles = 10;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
    logic       frame_done;
    logic [7:0] parity;
    logic [7:0] sequence_no;
  } framed_beat_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic push = 1'b0;
  logic full;
  logic [7:0] payload_byte_i = 8'h00;
  logic has_byte_i = 1'b0;
  logic end_of_message_i = 1'b0;
  logic empty;
  logic pop = 1'b0;
  logic [7:0] out_byte_o;
  logic last_of_run_o;
  logic frame_done_o;
  logic [7:0] parity_out_o;
  logic [7:0] sequence_out_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [bsf_pkg::CfgIdxW-1:0] cfg_index_i = bsf_pkg::RegFlag;
  logic [7:0] cfg_data_i = 8'h00;

  framed_beat_t framed_bytes_due[$];
  framed_beat_t beat_want;

  logic [7:0] flag_setting = bsf_pkg::FlagReset;
  logic [7:0] esc_setting = bsf_pkg::EscReset;
  logic frame_is_open = 1'b0;
  logic [7:0] parity_acc = 8'h00;
  logic [bsf_pkg::SeqBits-1:0] frame_seq = '0;

  int sender_idle_pct = 0;
  int receiver_idle_pct = 0;
  int mismatches = 0;
  int items_sent = 0;
  int beats_checked = 0;
  int frames_closed = 0;
  int reg_writes = 0;
  int stall_cycles = 0;

  byte_stuffing_framer_with_parity dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push             (push),
    .full             (full),
    .payload_byte_i   (payload_byte_i),
    .has_byte_i       (has_byte_i),
    .end_of_message_i (end_of_message_i),
    .empty            (empty),
    .pop              (pop),
    .out_byte_o       (out_byte_o),
    .last_of_run_o    (last_of_run_o),
    .frame_done_o     (frame_done_o),
    .parity_out_o     (parity_out_o),
    .sequence_out_o   (sequence_out_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  function automatic void queue_beat(logic [7:0] b, logic done, logic [7:0] par,
                                     logic [7:0] seq_no);
    framed_beat_t beat;
    beat.out_byte = b;
    beat.last_of_run = 1'b0;
    beat.frame_done = done;
    beat.parity = par;
    beat.sequence_no = seq_no;
    framed_bytes_due = {framed_bytes_due, beat};
  endfunction

  // Works out the framed beats that one accepted item produces.
  function automatic void frame_item(logic [7:0] b, logic has, logic eom);
    if (!has && !eom) return;
    if (!frame_is_open) begin
      queue_beat(flag_setting, 1'b0, 8'h00, 8'h00);
      frame_is_open = 1'b1;
    end
    if (has) begin
      parity_acc = parity_acc ^ b;
      if (b == flag_setting || b == esc_setting) queue_beat(esc_setting, 1'b0, 8'h00, 8'h00);
      queue_beat(b, 1'b0, 8'h00, 8'h00);
    end
    if (eom) begin
      queue_beat(flag_setting, 1'b1, parity_acc, 8'(frame_seq));
      frame_seq = frame_seq + bsf_pkg::SeqBits'(1);
      parity_acc = 8'h00;
      frame_is_open = 1'b0;
      frames_closed++;
    end
    framed_bytes_due[$].last_of_run = 1'b1;
  endfunction

  function automatic void compare_field(string fname, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $realtime, fname, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i) begin
    pop <= ($urandom_range(99) >= receiver_idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) begin
      beats_checked++;
      if (framed_bytes_due.size() == 0) begin
        $display("%0t: unexpected beat, expected none actual out_byte %0h", $realtime,
                 out_byte_o);
        mismatches++;
      end else begin
        beat_want = framed_bytes_due.pop_front();
        compare_field("out_byte", beat_want.out_byte, out_byte_o);
        compare_field("last_of_run", 8'(beat_want.last_of_run), 8'(last_of_run_o));
        compare_field("frame_done", 8'(beat_want.frame_done), 8'(frame_done_o));
        compare_field("parity_out", beat_want.parity, parity_out_o);
        compare_field("sequence_out", beat_want.sequence_no, sequence_out_o);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (push && !full) || (pop && !empty) || (cfg_valid_i && cfg_ready_o)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= StallLimit) begin
        $display("%0t: watchdog expired with %0d beats outstanding", $realtime,
                 framed_bytes_due.size());
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  task automatic send_item(input logic [7:0] b, input logic has, input logic eom);
    while ($urandom_range(99) < sender_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push <= 1'b1;
    payload_byte_i <= b;
    has_byte_i <= has;
    end_of_message_i <= eom;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    frame_item(b, has, eom);
    items_sent++;
  endtask

  task automatic settle();
    push <= 1'b0;
    while (framed_bytes_due.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [bsf_pkg::CfgIdxW-1:0] idx, input logic [7:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      bsf_pkg::RegFlag: flag_setting = value;
      bsf_pkg::RegEsc: esc_setting = value;
      default: ;
    endcase
    reg_writes++;
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic pick_settings();
    logic [7:0] f;
    logic [7:0] e;
    case ($urandom_range(4))
      0: begin f = bsf_pkg::FlagReset; e = bsf_pkg::EscReset; end
      1: begin f = 8'h00; e = 8'hFF; end
      2: begin f = 8'hFF; e = 8'h00; end
      3: begin f = 8'($urandom_range(255)); e = f; end
      default: begin f = 8'($urandom_range(255)); e = 8'($urandom_range(255)); end
    endcase
    write_reg(bsf_pkg::RegFlag, f);
    if ($urandom_range(3) == 0) write_reg(RegSpareA, 8'($urandom_range(255)));
    write_reg(bsf_pkg::RegEsc, e);
    if ($urandom_range(3) == 0) write_reg(RegSpareB, 8'($urandom_range(255)));
  endtask

  function automatic logic [7:0] pick_byte();
    int r;
    r = $urandom_range(99);
    if (r < 25) return flag_setting;
    if (r < 40) return esc_setting;
    return 8'($urandom_range(255));
  endfunction

  task automatic send_random_frame();
    int len;
    logic close_alone;
    len = $urandom_range(4);
    close_alone = (len == 0) || ($urandom_range(9) == 0);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(9) == 0) send_item(8'($urandom_range(255)), 1'b0, 1'b0);
      send_item(pick_byte(), 1'b1, !close_alone && (i == len - 1));
    end
    if (close_alone) send_item(8'($urandom_range(255)), 1'b0, 1'b1);
  endtask

  task automatic test_directed_defaults();
    send_item(8'h41, 1'b1, 1'b0);
    send_item(bsf_pkg::FlagReset, 1'b1, 1'b0);
    send_item(bsf_pkg::EscReset, 1'b1, 1'b0);
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'hFF, 1'b1, 1'b1);
    send_item(8'h00, 1'b0, 1'b1);
    send_item(8'h5A, 1'b0, 1'b0);
    send_item(8'h12, 1'b1, 1'b0);
    send_item(8'hED, 1'b0, 1'b1);
  endtask

  task automatic test_register_extremes();
    settle();
    write_reg(bsf_pkg::RegFlag, 8'h00);
    write_reg(bsf_pkg::RegEsc, 8'hFF);
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'hFF, 1'b1, 1'b0);
    send_item(8'h01, 1'b1, 1'b1);
    settle();
    write_reg(RegSpareA, 8'h55);
    write_reg(RegSpareB, 8'hAA);
    send_item(8'h55, 1'b1, 1'b0);
    send_item(8'hAA, 1'b1, 1'b1);
    settle();
    write_reg(bsf_pkg::RegFlag, 8'hAA);
    write_reg(bsf_pkg::RegEsc, 8'hAA);
    send_item(8'hAA, 1'b1, 1'b1);
  endtask

  task automatic test_register_change_mid_frame();
    send_item(8'h7E, 1'b1, 1'b0);
    settle();
    write_reg(bsf_pkg::RegFlag, 8'h7E);
    write_reg(bsf_pkg::RegEsc, 8'h7D);
    send_item(8'h7E, 1'b1, 1'b0);
    send_item(8'h7D, 1'b1, 1'b1);
    settle();
    write_reg(bsf_pkg::RegFlag, bsf_pkg::FlagReset);
    write_reg(bsf_pkg::RegEsc, bsf_pkg::EscReset);
  endtask

  task automatic test_random_traffic(input int count, input int s_idle, input int r_idle);
    int stop_at;
    logic paused;
    settle();
    sender_idle_pct = s_idle;
    receiver_idle_pct = r_idle;
    pick_settings();
    stop_at = items_sent + count;
    paused = 1'b0;
    while (items_sent < stop_at) begin
      send_random_frame();
      if (!paused && items_sent >= stop_at - count / 2) begin
        settle();
        paused = 1'b1;
      end
    end
  endtask

  // Closes empty frames until the sequence number has wrapped past zero.
  task automatic test_sequence_wrap();
    settle();
    sender_idle_pct = 0;
    receiver_idle_pct = 0;
    while (frames_closed < (1 << bsf_pkg::SeqBits) + 4) begin
      send_item(8'($urandom_range(255)), 1'b0, 1'b1);
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    sender_idle_pct = 20;
    receiver_idle_pct = 50;
    test_directed_defaults();
    test_register_extremes();
    test_register_change_mid_frame();
    test_random_traffic(35, 20, 50);
    test_random_traffic(35, 50, 20);
    test_random_traffic(35, 0, 0);
    test_sequence_wrap();
    settle();
    $display("Covered %0d items, %0d framed beats, %0d frames and %0d register writes.",
             items_sent, beats_checked, frames_closed, reg_writes);
    $display("Mismatches seen: %0d.", mismatches);
    if (mismatches == 0 && framed_bytes_due.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
